FILE: hdl/clbs_pkg.sv
// ---------------------------------------------------------------------------
// clbs_pkg
// Shared types, codes and constants of the character LCD bus sequencer.
// ---------------------------------------------------------------------------
package clbs_pkg;

    localparam int COLUMNS_DEF = 16;
    localparam int LINES_DEF   = 4;

    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int LINE_W = 3;
    localparam int COL_W  = 5;
    localparam int NIB_W  = 4;
    localparam int WAIT_W = 18;
    localparam int ADDR_W = 7;
    localparam int BLR_W  = 16;
    localparam int BKL_W  = 24;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 24;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] DDRAM_CMD  = 8'h80;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_INIT    = 3'd1,
        OP_CMD     = 3'd2,
        OP_DATA    = 3'd3,
        OP_BUF_WR  = 3'd4,
        OP_CLR     = 3'd5,
        OP_REFRESH = 3'd6,
        OP_BKL     = 3'd7
    } t_opcode;

    typedef enum logic [CIDX_W-1:0] {
        REG_LINE1 = 3'd0,
        REG_LINE2 = 3'd1,
        REG_LINE3 = 3'd2,
        REG_LINE4 = 3'd3,
        REG_BLINK = 3'd4,
        REG_BKL   = 3'd5,
        REG_GREEN = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_BYTE_HI,
        S_BYTE_LO,
        S_READ,
        S_CLEAR,
        S_NOTE
    } t_state;

    // init sequence step, strobe, nibble, wait
    localparam int INIT_STEPS = 17;
    localparam int INIT_W     = 5;

    function automatic logic [NIB_W+WAIT_W:0] init_rom(input logic [INIT_W-1:0] k);
        logic [NIB_W+WAIT_W:0] v;
        unique case (k)
            5'd0:    v = {1'b0, 4'h0, 18'd250000};
            5'd1:    v = {1'b1, 4'h3, 18'd5000};
            5'd2:    v = {1'b1, 4'h3, 18'd1000};
            5'd3:    v = {1'b1, 4'h3, 18'd1000};
            5'd4:    v = {1'b1, 4'h2, 18'd1000};
            5'd5:    v = {1'b1, 4'h2, 18'd0};
            5'd6:    v = {1'b1, 4'hC, 18'd50};
            5'd7:    v = {1'b1, 4'h0, 18'd0};
            5'd8:    v = {1'b1, 4'h8, 18'd50};
            5'd9:    v = {1'b1, 4'h0, 18'd0};
            5'd10:   v = {1'b1, 4'h1, 18'd5050};
            5'd11:   v = {1'b1, 4'h0, 18'd0};
            5'd12:   v = {1'b1, 4'h6, 18'd50};
            5'd13:   v = {1'b1, 4'h0, 18'd0};
            5'd14:   v = {1'b1, 4'hC, 18'd50};
            5'd15:   v = {1'b1, 4'h0, 18'd0};
            5'd16:   v = {1'b1, 4'h2, 18'd5050};
            default: v = '0;
        endcase
        return v;
    endfunction

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the input item and run timers
        logic emit;       // present a result
        logic strobe;
        logic rs;
        logic use_init;   // nibble/wait from init rom
        logic use_lo;     // low nibble of byte register
        logic byte_cmd;   // load byte reg from refresh command
        logic byte_mem;   // load byte reg from store read data
        logic mem_rd;
        logic mem_wr;
        logic mem_clr;
        logic cnt_clr;
        logic cnt_inc;
        logic last;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;
        logic cnt_end;
        logic init_end;
        logic line_ok;
        logic col_ok;
    } t_sts;

endpackage

FILE: hdl/clbs_if.sv
// ---------------------------------------------------------------------------
// clbs_if
// Valid/ready channels: input items, results and register writes.
// ---------------------------------------------------------------------------
interface clbs_in_if;
    logic                             valid;
    logic                             ready;
    logic [clbs_pkg::OP_W-1:0]        opcode;
    logic [clbs_pkg::BYTE_W-1:0]      byte_value;
    logic [clbs_pkg::LINE_W-1:0]      line_number;
    logic [clbs_pkg::COL_W-1:0]       column_number;
    modport source (output valid, opcode, byte_value, line_number, column_number,
                    input ready);
    modport sink (input valid, opcode, byte_value, line_number, column_number,
                  output ready);
endinterface

interface clbs_out_if;
    logic                             valid;
    logic                             ready;
    logic                             is_strobe;
    logic                             reg_select;
    logic [clbs_pkg::NIB_W-1:0]       bus_nibble;
    logic [clbs_pkg::WAIT_W-1:0]      wait_us;
    logic                             blink_phase;
    logic                             backlight_on;
    logic                             last_of_run;
    modport source (output valid, is_strobe, reg_select, bus_nibble, wait_us,
                    blink_phase, backlight_on, last_of_run, input ready);
    modport sink (input valid, is_strobe, reg_select, bus_nibble, wait_us,
                  blink_phase, backlight_on, last_of_run, output ready);
endinterface

interface clbs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [clbs_pkg::CIDX_W-1:0]      index;
    logic [clbs_pkg::CDAT_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/char_lcd_bus_sequencer_core.sv
// ---------------------------------------------------------------------------
// char_lcd_bus_sequencer_core
// Character LCD sequencer for a 4-bit bus with line buffer and timers.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in        in   valid/ready        opcode, byte, line, column
//  out       out  valid/ready        strobe, rs, nibble, wait, status, last
//  cfg       in   valid/ready        register index, data
//
// a new item is taken only once the last one is through; a refresh reads
// each character from the store before its two nibbles; a buffer write is
// done at load, a line clear writes spaces across a valid line.
// reset leaves the store reading as spaces through per-entry valid bits.
// a stalled result holds any state that presents one; cfg is always ready.
module char_lcd_bus_sequencer_core #(
    parameter int COLUMNS = clbs_pkg::COLUMNS_DEF,
    parameter int LINES   = clbs_pkg::LINES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clbs_in_if.sink     in_ch,
    clbs_out_if.source  out_ch,
    clbs_cfg_if.sink    cfg_ch
);
    clbs_pkg::t_ctl w_ctl;
    clbs_pkg::t_sts w_sts;

    assign cfg_ch.ready = 1'b1;

    clbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_opcode   (in_ch.opcode),
        .o_in_ready (in_ch.ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    clbs_dp #(.COLUMNS(COLUMNS), .LINES(LINES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_opcode        (in_ch.opcode),
        .i_byte_value    (in_ch.byte_value),
        .i_line_number   (in_ch.line_number),
        .i_column_number (in_ch.column_number),
        .i_cfg_valid     (cfg_ch.valid),
        .i_cfg_index     (cfg_ch.index),
        .i_cfg_data      (cfg_ch.data),
        .o_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .o_is_strobe     (out_ch.is_strobe),
        .o_reg_select    (out_ch.reg_select),
        .o_bus_nibble    (out_ch.bus_nibble),
        .o_wait_us       (out_ch.wait_us),
        .o_blink_phase   (out_ch.blink_phase),
        .o_backlight_on  (out_ch.backlight_on),
        .o_last_of_run   (out_ch.last_of_run)
    );
endmodule

FILE: hdl/clbs_ctrl.sv
// ---------------------------------------------------------------------------
// clbs_ctrl
// Sequencer state machine: steps through strobes of one input item.
// ---------------------------------------------------------------------------
module clbs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [clbs_pkg::OP_W-1:0]     i_opcode,
    output logic                          o_in_ready,
    input  clbs_pkg::t_sts                i_sts,
    output clbs_pkg::t_ctl                o_ctl
);
    clbs_pkg::t_state r_state, n_state;
    logic             r_rs, n_rs;
    logic             r_refresh, n_refresh;
    logic             r_ref_op, n_ref_op;
    clbs_pkg::t_opcode w_op;

    assign w_op = clbs_pkg::t_opcode'(i_opcode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= clbs_pkg::S_IDLE;
            r_rs      <= 1'b0;
            r_refresh <= 1'b0;
            r_ref_op  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rs      <= n_rs;
            r_refresh <= n_refresh;
            r_ref_op  <= n_ref_op;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_rs       = r_rs;
        n_refresh  = r_refresh;
        n_ref_op   = r_ref_op;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            clbs_pkg::S_IDLE: begin
                o_in_ready = !i_sts.out_busy;
                if (i_in_valid && !i_sts.out_busy) begin
                    o_ctl.load    = 1'b1;
                    o_ctl.cnt_clr = 1'b1;
                    n_refresh     = 1'b0;
                    n_ref_op      = (w_op == clbs_pkg::OP_REFRESH);
                    unique case (w_op)
                        clbs_pkg::OP_INIT: n_state = clbs_pkg::S_INIT;
                        clbs_pkg::OP_CMD: begin
                            n_rs = 1'b0;
                            n_state = clbs_pkg::S_BYTE_HI;
                        end
                        clbs_pkg::OP_DATA: begin
                            n_rs = 1'b1;
                            n_state = clbs_pkg::S_BYTE_HI;
                        end
                        clbs_pkg::OP_CLR: n_state = clbs_pkg::S_CLEAR;
                        clbs_pkg::OP_REFRESH: n_state = clbs_pkg::S_NOTE;
                        default: n_state = clbs_pkg::S_NOTE;
                    endcase
                end
            end
            clbs_pkg::S_NOTE: begin
                // refresh of a valid line goes out as command then bytes
                if (r_ref_op && r_refresh == 1'b0 && i_sts.line_ok && i_sts.init_end) begin
                    o_ctl.byte_cmd = 1'b1;
                    n_rs      = 1'b0;
                    n_refresh = 1'b1;
                    n_state   = clbs_pkg::S_BYTE_HI;
                end else if (!i_sts.out_busy) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.last = 1'b1;
                    n_state    = clbs_pkg::S_IDLE;
                end
            end
            clbs_pkg::S_INIT: begin
                if (!i_sts.out_busy) begin
                    o_ctl.emit     = 1'b1;
                    o_ctl.use_init = 1'b1;
                    o_ctl.cnt_inc  = 1'b1;
                    if (i_sts.cnt_end) begin
                        o_ctl.last = 1'b1;
                        n_state    = clbs_pkg::S_IDLE;
                    end
                end
            end
            clbs_pkg::S_BYTE_HI: begin
                if (!i_sts.out_busy) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.strobe = 1'b1;
                    o_ctl.rs     = r_rs;
                    n_state      = clbs_pkg::S_BYTE_LO;
                end
            end
            clbs_pkg::S_BYTE_LO: begin
                if (!i_sts.out_busy) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.strobe = 1'b1;
                    o_ctl.rs     = r_rs;
                    o_ctl.use_lo = 1'b1;
                    if (r_refresh && !i_sts.cnt_end) begin
                        o_ctl.mem_rd = 1'b1;
                        n_state      = clbs_pkg::S_READ;
                    end else begin
                        o_ctl.last = 1'b1;
                        n_state    = clbs_pkg::S_IDLE;
                    end
                end
            end
            clbs_pkg::S_READ: begin
                // store read data is valid now
                o_ctl.byte_mem = 1'b1;
                o_ctl.cnt_inc  = 1'b1;
                n_rs           = 1'b1;
                n_state        = clbs_pkg::S_BYTE_HI;
            end
            clbs_pkg::S_CLEAR: begin
                if (i_sts.line_ok && !i_sts.cnt_end) begin
                    o_ctl.mem_clr = 1'b1;
                    o_ctl.cnt_inc = 1'b1;
                end else begin
                    n_state = clbs_pkg::S_NOTE;
                end
            end
            default: n_state = clbs_pkg::S_IDLE;
        endcase
        // buffer write happens at load
        if (r_state == clbs_pkg::S_IDLE && i_in_valid && !i_sts.out_busy
            && w_op == clbs_pkg::OP_BUF_WR)
            o_ctl.mem_wr = 1'b1;
    end
endmodule

FILE: hdl/clbs_dp.sv
// ---------------------------------------------------------------------------
// clbs_dp
// Datapath: character store, timers, registers and the result register.
// ---------------------------------------------------------------------------
module clbs_dp #(
    parameter int COLUMNS = clbs_pkg::COLUMNS_DEF,
    parameter int LINES   = clbs_pkg::LINES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clbs_pkg::t_ctl                i_ctl,
    output clbs_pkg::t_sts                o_sts,
    input  logic [clbs_pkg::OP_W-1:0]     i_opcode,
    input  logic [clbs_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic [clbs_pkg::LINE_W-1:0]   i_line_number,
    input  logic [clbs_pkg::COL_W-1:0]    i_column_number,
    input  logic                          i_cfg_valid,
    input  logic [clbs_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [clbs_pkg::CDAT_W-1:0]   i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_is_strobe,
    output logic                          o_reg_select,
    output logic [clbs_pkg::NIB_W-1:0]    o_bus_nibble,
    output logic [clbs_pkg::WAIT_W-1:0]   o_wait_us,
    output logic                          o_blink_phase,
    output logic                          o_backlight_on,
    output logic                          o_last_of_run
);
    localparam int DEPTH = LINES * COLUMNS;
    localparam int MA_W  = $clog2(DEPTH);
    localparam int CN_W  = $clog2(COLUMNS + 1) > clbs_pkg::INIT_W ?
                           $clog2(COLUMNS + 1) : clbs_pkg::INIT_W;
    localparam int LI_W  = (LINES > 1) ? $clog2(LINES) : 1;

    logic [7:0]                         r_mem [DEPTH];
    logic [DEPTH-1:0]                   r_vld;
    logic [7:0]                         r_rdata;
    logic                               r_rvld;

    logic [clbs_pkg::ADDR_W-1:0]        r_laddr [4];
    logic [clbs_pkg::BLR_W-1:0]         r_blink_reload;
    logic [clbs_pkg::BKL_W-1:0]         r_bkl_reload;
    logic                               r_green;

    logic [clbs_pkg::BLR_W-1:0]         r_blink_cnt, n_blink_cnt;
    logic                               r_blink;
    logic [clbs_pkg::BKL_W-1:0]         r_bkl_cnt;
    logic                               r_bkl;

    logic [clbs_pkg::OP_W-1:0]          r_op;
    logic [7:0]                         r_byte;
    logic [clbs_pkg::LINE_W-1:0]        r_line;
    logic                               r_line_ok;
    logic [CN_W-1:0]                    r_cnt;
    logic [MA_W-1:0]                    r_base;

    logic                               r_ov;
    logic                               r_strobe, r_rs, r_last;
    logic [3:0]                         r_nib;
    logic [clbs_pkg::WAIT_W-1:0]        r_wait;

    logic                               w_line_ok, w_col_ok;
    logic [LI_W-1:0]                    w_lidx;
    logic [MA_W-1:0]                    w_wr_addr, w_rd_addr;
    logic [clbs_pkg::NIB_W+clbs_pkg::WAIT_W:0] w_init;

    assign w_line_ok = (i_line_number >= clbs_pkg::LINE_W'(1))
                    && (i_line_number <= clbs_pkg::LINE_W'(LINES));
    assign w_col_ok  = (i_column_number < clbs_pkg::COL_W'(COLUMNS));
    assign w_lidx    = LI_W'(i_line_number - clbs_pkg::LINE_W'(1));
    assign w_wr_addr = MA_W'(w_lidx * COLUMNS) + MA_W'(i_column_number);
    assign w_rd_addr = r_base + MA_W'(r_cnt);
    assign w_init    = clbs_pkg::init_rom(clbs_pkg::INIT_W'(r_cnt));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) r_line_ok <= w_line_ok;
    end

    assign o_sts.out_busy = r_ov && !i_out_ready;
    assign o_sts.line_ok  = r_line_ok;
    assign o_sts.init_end = 1'b1;
    assign o_sts.col_ok   = w_col_ok;
    assign o_sts.cnt_end  = (r_op == clbs_pkg::OP_INIT)
                          ? (r_cnt == CN_W'(clbs_pkg::INIT_STEPS - 1))
                          : (r_cnt == CN_W'(COLUMNS));

    // store: write port (buffer write or line clear), registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.mem_wr && w_line_ok && w_col_ok)
            r_mem[w_wr_addr] <= i_byte_value;
        else if (i_ctl.mem_clr)
            r_mem[w_rd_addr] <= clbs_pkg::SPACE_CHAR;
        if (i_ctl.mem_rd) begin
            r_rdata <= r_mem[w_rd_addr];
            r_rvld  <= r_vld[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (i_ctl.mem_wr && w_line_ok && w_col_ok) r_vld[w_wr_addr] <= 1'b1;
        else if (i_ctl.mem_clr) r_vld[w_rd_addr] <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_laddr[0]     <= 7'd0;
            r_laddr[1]     <= 7'd64;
            r_laddr[2]     <= 7'd20;
            r_laddr[3]     <= 7'd84;
            r_blink_reload <= 16'd500;
            r_bkl_reload   <= 24'd30000;
            r_green        <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (clbs_pkg::t_reg_idx'(i_cfg_index))
                clbs_pkg::REG_LINE1: r_laddr[0] <= i_cfg_data[6:0];
                clbs_pkg::REG_LINE2: r_laddr[1] <= i_cfg_data[6:0];
                clbs_pkg::REG_LINE3: r_laddr[2] <= i_cfg_data[6:0];
                clbs_pkg::REG_LINE4: r_laddr[3] <= i_cfg_data[6:0];
                clbs_pkg::REG_BLINK: r_blink_reload <= i_cfg_data[15:0];
                clbs_pkg::REG_BKL:   r_bkl_reload <= i_cfg_data;
                clbs_pkg::REG_GREEN: r_green <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // timers
    assign n_blink_cnt = r_blink_cnt - 16'd1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_cnt <= 16'd500;
            r_blink     <= 1'b0;
            r_bkl_cnt   <= '0;
            r_bkl       <= 1'b0;
        end else if (i_ctl.load) begin
            if (i_opcode == clbs_pkg::OP_TICK) begin
                if (n_blink_cnt == '0) begin
                    r_blink_cnt <= r_blink_reload;
                    r_blink     <= !r_blink;
                end else begin
                    r_blink_cnt <= n_blink_cnt;
                end
                if (r_green && r_bkl_cnt != '0) begin
                    r_bkl_cnt <= r_bkl_cnt - 24'd1;
                    if (r_bkl_cnt == 24'd1) r_bkl <= 1'b0;
                end
            end else if (i_opcode == clbs_pkg::OP_BKL) begin
                r_bkl_cnt <= r_bkl_reload;
                r_bkl     <= 1'b1;
            end
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op   <= i_opcode;
            r_byte <= i_byte_value;
            r_line <= i_line_number;
            r_base <= MA_W'(w_lidx * COLUMNS);
        end else if (i_ctl.byte_cmd) begin
            r_byte <= clbs_pkg::DDRAM_CMD | {1'b0, r_laddr[2'(r_line - 3'd1)]};
        end else if (i_ctl.byte_mem) begin
            r_byte <= r_rvld ? r_rdata : clbs_pkg::SPACE_CHAR;
        end
        if (i_ctl.cnt_clr)      r_cnt <= '0;
        else if (i_ctl.cnt_inc) r_cnt <= r_cnt + CN_W'(1);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (i_ctl.emit) r_ov <= 1'b1;
        else if (i_out_ready) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_last <= i_ctl.last;
            if (i_ctl.use_init) begin
                r_strobe <= w_init[clbs_pkg::NIB_W+clbs_pkg::WAIT_W];
                r_rs     <= 1'b0;
                r_nib    <= w_init[clbs_pkg::NIB_W+clbs_pkg::WAIT_W-1:clbs_pkg::WAIT_W];
                r_wait   <= w_init[clbs_pkg::WAIT_W-1:0];
            end else begin
                r_strobe <= i_ctl.strobe;
                r_rs     <= i_ctl.rs;
                r_nib    <= !i_ctl.strobe ? 4'h0 :
                            (i_ctl.use_lo ? r_byte[3:0] : r_byte[7:4]);
                r_wait   <= i_ctl.use_lo ? clbs_pkg::WAIT_W'(50) : '0;
            end
        end
    end

    assign o_out_valid    = r_ov;
    assign o_is_strobe    = r_strobe;
    assign o_reg_select   = r_rs;
    assign o_bus_nibble   = r_nib;
    assign o_wait_us      = r_wait;
    assign o_blink_phase  = r_blink;
    assign o_backlight_on = r_bkl;
    assign o_last_of_run  = r_last;
endmodule
